[rtl/core/pcpc_pkg.sv]
package pcpc_pkg;

    // Bits of one sequence counted together in the first level of a lane's popcount tree.
    localparam int GRP = 8;

    // Load strobes for the registered stages inside each lane.
    typedef struct packed {
        logic xr;   // mismatch vectors
        logic grp;  // per-group mismatch counts
        logic chk;  // lane verdict
    } t_lane_en;

endpackage

[rtl/core/periodic_complementary_pair_check.sv]
// Periodic complementary pair check. Each input transfer carries two +1/-1
// sequences packed as bit vectors (1 = +1, 0 = -1, bit i = element i); the
// block answers with one output transfer whose o_is_pair is 1 when, for every
// cyclic shift u in 1..L-1, the mismatch counts of A and of B against their
// own rotation by u add up to L. L comes from the seq_length register: it is
// written by pulsing i_seq_length_we with i_seq_length, and the user must write
// it only while no pair is in flight (the block itself does not enforce this);
// 0 acts as 1 and values above MAX_LENGTH saturate. Bits of the sequences at or
// above L are ignored. There is one lane per nonzero shift (MAX_LENGTH-1 lanes);
// every lane rotates, compares and counts on its own, and a final AND combines
// the lane verdicts. The block takes one pair every clock cycle while the output
// keeps accepting. Five register stages sit between input and output: an input
// register, the lane mismatch register, the first popcount level, the lane
// verdict and the merged output register. The input register loads at the
// input transfer edge, and o_valid rises once the pair reaches the last stage.
// Each stage holds under output backpressure and drains into any empty stage
// ahead of it, so the input accepts while a result waits until all stages fill.
module periodic_complementary_pair_check #(
    parameter int MAX_LENGTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_seq_length_we,
    input  logic [6:0]  i_seq_length,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_seq_a,
    input  logic [63:0] i_seq_b,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_is_pair
);

    localparam int W  = MAX_LENGTH;
    localparam int LW = $clog2(MAX_LENGTH + 1);
    localparam int NL = (MAX_LENGTH > 1) ? MAX_LENGTH - 1 : 1;
    localparam int NS = 5;
    localparam logic [LW-1:0] LEN_MAX = LW'(MAX_LENGTH);

    logic [LW-1:0]        r_len, n_len;
    logic [NS:1]          r_vld;
    logic [NS+1:1]        rdy;
    logic [NS:1]          ld;
    logic [W-1:0]         mask;
    logic [W-1:0]         r_a, r_b;
    logic [NL-1:0]        lane_ok;
    pcpc_pkg::t_lane_en   lane_en;

    // Saturate the written length into 1..MAX_LENGTH.
    always_comb begin
        if (i_seq_length == 7'd0) begin
            n_len = LW'(1);
        end else if ({25'd0, i_seq_length} > MAX_LENGTH) begin
            n_len = LEN_MAX;
        end else begin
            n_len = LW'(i_seq_length);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_MAX;
        end else if (i_seq_length_we) begin
            r_len <= n_len;
        end
    end

    // Stage k advances when it is empty or its content moves on this cycle.
    always_comb begin
        rdy[NS+1] = i_ready;
        for (int k = NS; k >= 1; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    assign o_ready = rdy[1] && i_rst_n;

    // Load payload only when a valid transfer actually enters the stage.
    always_comb begin
        ld[1] = rdy[1] && i_valid;
        for (int k = 2; k <= NS; k++) begin
            ld[k] = rdy[k] && r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[1]) begin
                r_vld[1] <= i_valid;
            end
            for (int k = 2; k <= NS; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Drop the bits at or above the current length on the way in.
    always_comb begin
        for (int n = 0; n < W; n++) begin
            mask[n] = (LW'(n) < r_len);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld[1]) begin
            r_a <= i_seq_a[W-1:0] & mask;
            r_b <= i_seq_b[W-1:0] & mask;
        end
    end

    assign lane_en.xr  = ld[2];
    assign lane_en.grp = ld[3];
    assign lane_en.chk = ld[4];

    // One lane per nonzero shift.
    for (genvar u = 0; u < NL; u++) begin : g_lane
        pcpc_lane #(
            .W  (W),
            .LW (LW),
            .U  (u + 1)
        ) u_lane (
            .i_clk (i_clk),
            .i_en  (lane_en),
            .i_a   (r_a),
            .i_b   (r_b),
            .i_len (r_len),
            .o_ok  (lane_ok[u])
        );
    end

    pcpc_merge #(
        .NL (NL)
    ) u_merge (
        .i_clk  (i_clk),
        .i_en   (ld[5]),
        .i_ok   (lane_ok),
        .o_pair (o_is_pair)
    );

    // Hold the output side quiet while in reset.
    assign o_valid = r_vld[NS] && i_rst_n;

endmodule

[rtl/core/pcpc_lane.sv]
module pcpc_lane #(
    parameter int W  = 64,
    parameter int LW = 7,
    parameter int U  = 1
) (
    input  logic                 i_clk,
    input  pcpc_pkg::t_lane_en   i_en,
    input  logic [W-1:0]         i_a,
    input  logic [W-1:0]         i_b,
    input  logic [LW-1:0]        i_len,
    output logic                 o_ok
);

    localparam int NG   = (W + pcpc_pkg::GRP - 1) / pcpc_pkg::GRP;
    localparam int WP   = NG * pcpc_pkg::GRP;
    localparam int GCW  = $clog2(2 * pcpc_pkg::GRP + 1);
    localparam int TW   = $clog2(2 * W + 1);
    localparam logic [LW-1:0] U_L = LW'(U);

    logic [W-1:0]   mask;
    logic [LW-1:0]  sh;
    logic           act;
    logic [W-1:0]   n_xa, n_xb;
    logic [W-1:0]   r_xa, r_xb;
    logic [WP-1:0]  pa, pb;
    logic [GCW-1:0] n_grp [NG];
    logic [GCW-1:0] r_grp [NG];
    logic [TW-1:0]  total;
    logic           n_ok, r_ok;

    // Rotation by this lane's shift, modulo the current length.
    always_comb begin
        for (int n = 0; n < W; n++) begin
            mask[n] = (LW'(n) < i_len);
        end
        act  = (U_L < i_len);
        sh   = i_len - U_L;
        n_xa = '0;
        n_xb = '0;
        if (act) begin
            n_xa = i_a ^ (((i_a >> U) | (i_a << sh)) & mask);
            n_xb = i_b ^ (((i_b >> U) | (i_b << sh)) & mask);
        end
    end

    assign pa = WP'(r_xa);
    assign pb = WP'(r_xb);

    always_comb begin
        for (int g = 0; g < NG; g++) begin
            n_grp[g] = '0;
            for (int j = 0; j < pcpc_pkg::GRP; j++) begin
                n_grp[g] = n_grp[g] + GCW'(pa[g*pcpc_pkg::GRP + j])
                                    + GCW'(pb[g*pcpc_pkg::GRP + j]);
            end
        end
    end

    // Idle lanes (shift at or beyond the length) pass.
    always_comb begin
        total = '0;
        for (int g = 0; g < NG; g++) begin
            total = total + TW'(r_grp[g]);
        end
        n_ok = !act || (total == TW'(i_len));
    end

    always_ff @(posedge i_clk) begin
        if (i_en.xr) begin
            r_xa <= n_xa;
            r_xb <= n_xb;
        end
        if (i_en.grp) begin
            r_grp <= n_grp;
        end
        if (i_en.chk) begin
            r_ok <= n_ok;
        end
    end

    assign o_ok = r_ok;

endmodule

[rtl/core/pcpc_merge.sv]
module pcpc_merge #(
    parameter int NL = 63
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NL-1:0] i_ok,
    output logic          o_pair
);

    logic r_pair;

    // A pair passes only if every shift lane passed.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pair <= &i_ok;
        end
    end

    assign o_pair = r_pair;

endmodule

[rtl/core/pcpc_checker.sv]
module pcpc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready,
    input logic o_is_pair
);

    logic       acc_in, acc_out;
    logic [2:0] r_cnt;

    assign acc_in  = i_valid && o_ready;
    assign acc_out = o_valid && i_ready;

    // Track pairs accepted but not yet delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + 3'(acc_in) - 3'(acc_out);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_is_pair))
        else $error("result changed while stalled");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_cnt != 3'd0)
        else $error("result without a pending pair");

    a_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd5)
        else $error("more pairs in flight than pipeline stages");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 3'd0 |-> o_ready)
        else $error("empty pipeline refused a pair");

endmodule

bind periodic_complementary_pair_check pcpc_checker u_pcpc_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (i_valid),
    .o_ready   (o_ready),
    .o_valid   (o_valid),
    .i_ready   (i_ready),
    .o_is_pair (o_is_pair)
);
